[hw/rtl/vid_pkg.sv]
// ----------------------------------------------------------------------------
// vid_pkg
// Shared types and constants of the vertex index deduplicator.
// ----------------------------------------------------------------------------
`default_nettype none

package vid_pkg;

   localparam int OUT_INDEX_BITS = 24;
   localparam int HASH_BITS      = 32;
   localparam int EPOCH_BITS     = 8;
   localparam int MOD_STEPS      = 3;
   localparam int MIX_SHIFT      = 15;

   localparam logic [HASH_BITS-1:0] HASH_P = 32'h9E37_79B1;
   localparam logic [HASH_BITS-1:0] HASH_T = 32'h85EB_CA77;
   localparam logic [HASH_BITS-1:0] HASH_N = 32'hC2B2_AE3D;

   localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
   localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = '1;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_HASH  = 8'b0000_0100,
      ST_MIX   = 8'b0000_1000,
      ST_MOD   = 8'b0001_0000,
      ST_READ  = 8'b0010_0000,
      ST_CMP   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic mix;
      logic mod_step;
      logic compare;
      logic finish;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic need_clear;
      logic no_normal;
      logic mod_last;
      logic probe_done;
      logic clear_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/vid_ctrl.sv]
// ----------------------------------------------------------------------------
// vid_ctrl
// Sequencer: clearing sweep, hashing, probing and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module vid_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  vid_pkg::status_type   status,
   output vid_pkg::cmd_type      cmd
);
   import vid_pkg::*;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   always_comb begin
      state_in   = state_ff;
      pend_in    = pend_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = pend_ff ? ST_HASH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               pend_in  = 1'b1;
               state_in = status.need_clear ? ST_CLEAR : ST_HASH;
            end
         end
         ST_HASH: begin
            state_in = status.no_normal ? ST_DONE : ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            state_in    = status.probe_done ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result overwritten while still held");

   a_compare_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.compare |-> $past(state_ff == ST_READ))
      else $error("compare without a table read");

endmodule

`default_nettype wire

[hw/rtl/vid_datapath.sv]
// ----------------------------------------------------------------------------
// vid_datapath
// Item registers, hash unit, slot reduction, table memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vid_datapath #(
   parameter int TABLE_DEPTH       = 4096,
   parameter int SOURCE_INDEX_BITS = 20,
   parameter int COUNT_BITS        = 24,
   parameter int IN_TDATA_BITS     = 64,
   parameter int OUT_TDATA_BITS    = 96
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  vid_pkg::cmd_type               cmd,
   output vid_pkg::status_type            status,
   input  wire logic [IN_TDATA_BITS-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [OUT_TDATA_BITS-1:0]      rsp_tdata
);
   import vid_pkg::*;

   localparam int SIB       = SOURCE_INDEX_BITS;
   localparam int TN_BITS   = SIB + 1;
   localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
   localparam int KEY_BITS  = SIB + 2 * TN_BITS;
   localparam int MEM_BITS  = EPOCH_BITS + KEY_BITS + COUNT_BITS;
   localparam int MCNT_BITS = $clog2(MOD_STEPS);

   localparam logic [ADDR_BITS-1:0]  LAST_SLOT = ADDR_BITS'(TABLE_DEPTH - 1);
   localparam logic [ADDR_BITS:0]    DEPTH_R   = (ADDR_BITS + 1)'(TABLE_DEPTH);
   localparam logic [MCNT_BITS-1:0]  MOD_LAST  = MCNT_BITS'(MOD_STEPS - 1);
   localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
   localparam logic [HASH_BITS-1:0]  RECIP     =
      HASH_BITS'((64'd1 << HASH_BITS) / TABLE_DEPTH);
   localparam logic [HASH_BITS-1:0]  DEPTH_H   = HASH_BITS'(TABLE_DEPTH);

   // input unpack
   logic               in_mesh;
   logic [SIB-1:0]     in_pos;
   logic [TN_BITS-1:0] in_tex, in_nrm, in_tex_norm, in_nrm_norm;

   assign in_mesh     = req_tdata[0];
   assign in_pos      = req_tdata[SIB:1];
   assign in_tex      = req_tdata[SIB+TN_BITS:SIB+1];
   assign in_nrm      = req_tdata[SIB+2*TN_BITS:SIB+TN_BITS+1];
   assign in_tex_norm = in_tex[SIB] ? '1 : in_tex;
   assign in_nrm_norm = in_nrm[SIB] ? '1 : in_nrm;

   logic [SIB-1:0]        pos_ff;
   logic [TN_BITS-1:0]    tex_ff, nrm_ff;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [COUNT_BITS-1:0] counter_ff, counter_in;
   logic [KEY_BITS-1:0]   key;
   logic                  no_normal;

   assign key       = {nrm_ff, tex_ff, pos_ff};
   assign no_normal = nrm_ff[SIB];

   // hash products, one multiplier each, registered
   logic [HASH_BITS-1:0] prod_p_ff, prod_t_ff, prod_n_ff, prod_x, hash_mix;

   assign prod_x   = prod_p_ff ^ prod_t_ff ^ prod_n_ff;
   assign hash_mix = prod_x ^ (prod_x >> MIX_SHIFT);

   always_ff @(posedge clock) begin
      prod_p_ff <= HASH_BITS'(pos_ff) * HASH_P;
      prod_t_ff <= HASH_BITS'(tex_ff) * HASH_T;
      prod_n_ff <= HASH_BITS'(nrm_ff) * HASH_N;
   end

   // slot = hash mod depth: reciprocal quotient estimate, remainder, one correction
   logic [HASH_BITS-1:0]   mod_h_ff, mod_h_in, mod_q_ff, mod_q_in, mod_rem;
   logic [2*HASH_BITS-1:0] mod_prod;
   logic [ADDR_BITS:0]     mod_r_ff, mod_r_in;
   logic [MCNT_BITS-1:0]   mod_cnt_ff, mod_cnt_in;

   assign mod_prod = (2 * HASH_BITS)'(mod_h_ff) * (2 * HASH_BITS)'(RECIP);
   assign mod_rem  = mod_h_ff - mod_q_ff * DEPTH_H;

   // table memory: {epoch, key, index}
   logic [MEM_BITS-1:0]   mem [TABLE_DEPTH];
   logic [MEM_BITS-1:0]   rd_ff, wr_data;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  slot_ff, slot_in, probe_ff, probe_in, clr_cnt_ff, clr_cnt_in;
   logic [EPOCH_BITS-1:0] rd_epoch;
   logic [KEY_BITS-1:0]   rd_key;
   logic [COUNT_BITS-1:0] rd_index;
   logic                  rd_live, rd_match, exhausted;

   assign rd_index  = rd_ff[COUNT_BITS-1:0];
   assign rd_key    = rd_ff[COUNT_BITS+KEY_BITS-1:COUNT_BITS];
   assign rd_epoch  = rd_ff[MEM_BITS-1:COUNT_BITS+KEY_BITS];
   assign rd_live   = (rd_epoch == epoch_ff);
   assign rd_match  = rd_live && (rd_key == key);
   assign exhausted = (probe_ff == LAST_SLOT);

   // probe outcome
   logic                  hit_ff, hit_in, place_ff, place_in, full_ff, full_in;
   logic [COUNT_BITS-1:0] hit_idx_ff, hit_idx_in;

   // result
   logic                      sat;
   logic [COUNT_BITS-1:0]     idx;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_TDATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   assign sat = !hit_ff && (counter_ff == CNT_MAX);
   assign idx = hit_ff ? hit_idx_ff : counter_ff;

   assign wr_en   = cmd.clear_step || (cmd.finish && place_ff);
   assign wr_addr = cmd.clear_step ? clr_cnt_ff : slot_ff;
   assign wr_data = cmd.clear_step ? {EPOCH_NONE, {(KEY_BITS + COUNT_BITS){1'b0}}}
                                   : {epoch_ff, key, counter_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[slot_ff];
   end

   always_comb begin
      epoch_in     = epoch_ff;
      counter_in   = counter_ff;
      mod_h_in     = mod_h_ff;
      mod_q_in     = mod_q_ff;
      mod_r_in     = mod_r_ff;
      mod_cnt_in   = mod_cnt_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      clr_cnt_in   = clr_cnt_ff;
      hit_in       = hit_ff;
      place_in     = place_ff;
      full_in      = full_ff;
      hit_idx_in   = hit_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         hit_in   = 1'b0;
         place_in = 1'b0;
         full_in  = 1'b0;
         if (in_mesh) begin
            counter_in = '0;
            epoch_in   = (epoch_ff == EPOCH_MAX) ? EPOCH_FIRST : epoch_ff + 1'b1;
         end
      end
      if (cmd.clear_step) begin
         clr_cnt_in = (clr_cnt_ff == LAST_SLOT) ? '0 : clr_cnt_ff + 1'b1;
      end
      if (cmd.mix) begin
         mod_h_in   = hash_mix;
         mod_cnt_in = '0;
      end
      if (cmd.mod_step) begin
         mod_q_in   = mod_prod[2*HASH_BITS-1:HASH_BITS];
         mod_r_in   = mod_rem[ADDR_BITS:0];
         mod_cnt_in = mod_cnt_ff + 1'b1;
         slot_in    = (mod_r_ff >= DEPTH_R) ? ADDR_BITS'(mod_r_ff - DEPTH_R)
                                            : mod_r_ff[ADDR_BITS-1:0];
         probe_in   = '0;
      end
      if (cmd.compare) begin
         if (!rd_live) begin
            place_in = 1'b1;
         end else if (rd_match) begin
            hit_in     = 1'b1;
            hit_idx_in = rd_index;
         end else if (exhausted) begin
            full_in = 1'b1;
         end else begin
            slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
            probe_in = probe_ff + 1'b1;
         end
      end
      if (cmd.finish) begin
         if (!hit_ff && !sat) begin
            counter_in = counter_ff + 1'b1;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = OUT_TDATA_BITS'({sat, full_ff, no_normal, key, !hit_ff,
                                         OUT_INDEX_BITS'(idx)});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_ff <= in_pos;
         tex_ff <= in_tex_norm;
         nrm_ff <= in_nrm_norm;
      end
      mod_h_ff    <= mod_h_in;
      mod_q_ff    <= mod_q_in;
      mod_r_ff    <= mod_r_in;
      slot_ff     <= slot_in;
      probe_ff    <= probe_in;
      hit_idx_ff  <= hit_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff     <= EPOCH_FIRST;
         counter_ff   <= '0;
         mod_cnt_ff   <= '0;
         clr_cnt_ff   <= '0;
         hit_ff       <= 1'b0;
         place_ff     <= 1'b0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         epoch_ff     <= epoch_in;
         counter_ff   <= counter_in;
         mod_cnt_ff   <= mod_cnt_in;
         clr_cnt_ff   <= clr_cnt_in;
         hit_ff       <= hit_in;
         place_ff     <= place_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.need_clear = in_mesh && (epoch_ff == EPOCH_MAX);
   assign status.no_normal  = no_normal;
   assign status.mod_last   = (mod_cnt_ff == MOD_LAST);
   assign status.probe_done = !rd_live || rd_match || exhausted;
   assign status.clear_last = (clr_cnt_ff == LAST_SLOT);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != EPOCH_NONE)
      else $error("current epoch equals the cleared mark");

   a_place_miss: assert property (@(posedge clock) disable iff (reset)
      place_ff |-> (!hit_ff && !full_ff))
      else $error("insert flagged on a hit or a full table");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      !cmd.load |=> (counter_ff >= $past(counter_ff)))
      else $error("vertex counter went back without a mesh start");

endmodule

`default_nettype wire

[hw/rtl/vertex_index_deduplicator_top.sv]
// A corner without a normal goes from accept through HASH to DONE; one with a
//   normal goes through HASH, MIX and MOD, then READ and CMP per table probe
//   (1..TABLE_DEPTH probes), then DONE. One item at a time: the next is accepted
//   in the cycle after the result is loaded; a held result stalls the input.
// Reset: synchronous; clears the counter, then sweeps every table slot with
//   req_tready low. Every 255th mesh start adds the same sweep.
// ----------------------------------------------------------------------------
// vertex_index_deduplicator_top
// Face corner to output vertex index mapping through a linear-probe hash table.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_index_deduplicator_top #(
   parameter int TABLE_DEPTH       = 4096,
   parameter int SOURCE_INDEX_BITS = 20,
   parameter int COUNT_BITS        = 24,
   localparam int IN_BITS          = 3 * SOURCE_INDEX_BITS + 3,
   localparam int IN_TDATA_BITS    = ((IN_BITS + 7) / 8) * 8,
   localparam int OUT_BITS         = 3 * SOURCE_INDEX_BITS + 30,
   localparam int OUT_TDATA_BITS   = ((OUT_BITS + 7) / 8) * 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // mesh_start, position_index, texcoord_index, normal_index
   input  wire logic [IN_TDATA_BITS-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // output_index, is_new, src_position, src_texcoord, src_normal,
   // use_face_normal, table_full, count_saturated
   output logic [OUT_TDATA_BITS-1:0]      rsp_tdata
);
   import vid_pkg::*;

   cmd_type    cmd;
   status_type status;

   vid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vid_datapath #(
      .TABLE_DEPTH       (TABLE_DEPTH),
      .SOURCE_INDEX_BITS (SOURCE_INDEX_BITS),
      .COUNT_BITS        (COUNT_BITS),
      .IN_TDATA_BITS     (IN_TDATA_BITS),
      .OUT_TDATA_BITS    (OUT_TDATA_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex index deduplicator. A local model of
// the probe table predicts every result item; stimulus covers directed edge
// cases and random meshes with reuse and forced hash collisions.
// Both stream sides stall in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int DEPTH     = 4096;
   localparam int IDX_W     = vid_pkg::OUT_INDEX_BITS;
   localparam int LIMIT     = 1_200_000;
   localparam int MAX_SHOWN = 50;
   localparam logic [20:0] ABSENT = 21'h1F_FFFF;

   typedef struct packed {
      logic        mesh_start;
      logic [19:0] pos;
      logic [20:0] tex;
      logic [20:0] nrm;
      logic        hold;
   } corner_t;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic             fresh;
      logic [19:0]      pos;
      logic [20:0]      tex;
      logic [20:0]      nrm;
      logic             face;
      logic             full;
      logic             sat;
   } vertex_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // mesh_start, position_index, texcoord_index, normal_index
   logic        rsp_tvalid;
   logic        rsp_tready;
   // output_index, is_new, src_position, src_texcoord, src_normal,
   // use_face_normal, table_full, count_saturated
   logic [95:0] rsp_tdata;

   corner_t corner_queue[$];
   vertex_t pending_vertices[$];
   corner_t next_corner;

   bit [DEPTH-1:0]   slot_used;
   logic [61:0]      slot_key [DEPTH];
   logic [IDX_W-1:0] slot_vertex [DEPTH];
   logic [IDX_W-1:0] vertex_count;

   int  corners_sent;
   int  corners_driven;
   int  total_corners;
   int  quiet_from;
   int  idle_level;
   int  req_gap;
   int  rsp_gap;
   int  fails;
   int  cycle_count;

   vertex_index_deduplicator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [20:0] canon_index(logic [20:0] raw);
      return raw[20] ? ABSENT : raw;
   endfunction

   function automatic logic [11:0] slot_of(logic [19:0] p, logic [20:0] t, logic [20:0] n);
      logic [31:0] h;
      h = (32'(p) * 32'h9E37_79B1) ^ (32'(t) * 32'h85EB_CA77) ^ (32'(n) * 32'hC2B2_AE3D);
      h = h ^ (h >> 15);
      return h[11:0];
   endfunction

   task automatic next_index(output logic [IDX_W-1:0] idx, output logic sat);
      if (vertex_count == '1) begin
         idx = '1;
         sat = 1'b1;
      end else begin
         idx = vertex_count;
         vertex_count = vertex_count + 1'b1;
         sat = 1'b0;
      end
   endtask

   task automatic dedup_corner(input corner_t c, output vertex_t v);
      logic [19:0] p;
      logic [20:0] t;
      logic [20:0] n;
      logic [11:0] s;
      int          k;
      p = c.pos;
      t = canon_index(c.tex);
      n = canon_index(c.nrm);
      if (c.mesh_start) begin
         slot_used = '0;
         vertex_count = '0;
      end
      v = '0;
      v.pos = p;
      v.tex = t;
      v.nrm = n;
      if (n == ABSENT) begin
         v.face = 1'b1;
         v.fresh = 1'b1;
         next_index(v.index, v.sat);
      end else begin
         s = slot_of(p, t, n);
         for (k = 0; k < DEPTH; k++) begin
            if (!slot_used[s] || slot_key[s] == {p, t, n}) break;
            s = s + 12'd1;
         end
         if (k < DEPTH && slot_used[s]) begin
            v.index = slot_vertex[s];
         end else begin
            v.fresh = 1'b1;
            next_index(v.index, v.sat);
            if (k < DEPTH) begin
               slot_used[s] = 1'b1;
               slot_key[s] = {p, t, n};
               slot_vertex[s] = v.index;
            end else begin
               v.full = 1'b1;
            end
         end
      end
   endtask

   task automatic add_corner(input logic ms, input logic [19:0] p, input logic [20:0] t,
                             input logic [20:0] n, input logic hold);
      corner_t c;
      c.mesh_start = ms;
      c.pos = p;
      c.tex = t;
      c.nrm = n;
      c.hold = hold;
      corner_queue.insert(corner_queue.size(), c);
   endtask

   // another position that lands on the same home slot
   function automatic logic [19:0] find_twin(logic [19:0] p, logic [20:0] t, logic [20:0] n);
      logic [11:0] home;
      logic [19:0] q;
      home = slot_of(p, canon_index(t), canon_index(n));
      for (int i = 0; i < (1 << 20); i++) begin
         q = 20'($urandom);
         if (q != p && slot_of(q, canon_index(t), canon_index(n)) == home) return q;
      end
      return p ^ 20'd1;
   endfunction

   function automatic logic [19:0] pick_pos();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 20'($urandom_range(0, 15));
      if (r < 55) return 20'h0_0000;
      if (r < 65) return 20'hF_FFFF;
      return 20'($urandom);
   endfunction

   function automatic logic [20:0] pick_attr();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return {1'b1, 20'($urandom)};
      if (r < 55) return 21'($urandom_range(0, 15));
      if (r < 60) return 21'h0F_FFFF;
      return {1'b0, 20'($urandom)};
   endfunction

   function automatic logic [20:0] reencode(logic [20:0] a);
      return a[20] ? {1'b1, 20'($urandom)} : a;
   endfunction

   function automatic bit idle_now();
      if (corners_sent >= quiet_from || idle_level == 0) return 1'b0;
      return $urandom_range(0, idle_level == 1 ? 7 : 2) == 0;
   endfunction

   task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
      if (want !== got) begin
         fails++;
         if (fails <= MAX_SHOWN)
            $display("%0t %s: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // input side: accept and predict
   always @(posedge clock) begin
      vertex_t v;
      if (!reset && req_tvalid && req_tready) begin
         dedup_corner(next_corner, v);
         pending_vertices.insert(pending_vertices.size(), v);
         corners_sent++;
         if (corners_sent % 100 == 0) idle_level = $urandom_range(0, 2);
      end
   end

   always @(negedge clock) begin
      if (!reset && corners_sent == corners_driven) begin
         if (req_gap != 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (corner_queue.size() != 0 &&
                      !(corner_queue[0].hold && pending_vertices.size() != 0)) begin
            next_corner = corner_queue.pop_front();
            req_tdata <= {1'b0, next_corner.nrm, next_corner.tex, next_corner.pos,
                          next_corner.mesh_start};
            req_tvalid <= 1'b1;
            corners_driven++;
            if (idle_now()) req_gap = $urandom_range(1, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side
   always @(negedge clock) begin
      if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_now()) rsp_gap = $urandom_range(1, 14);
      end
   end

   always @(posedge clock) begin
      vertex_t w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_vertices.size() == 0) begin
            fails++;
            if (fails <= MAX_SHOWN)
               $display("%0t unexpected item: expected none, actual %h", $time, rsp_tdata);
         end else begin
            w = pending_vertices.pop_front();
            check_field("output_index",    w.index,      rsp_tdata[23:0]);
            check_field("is_new",          24'(w.fresh), 24'(rsp_tdata[24]));
            check_field("src_position",    24'(w.pos),   24'(rsp_tdata[44:25]));
            check_field("src_texcoord",    24'(w.tex),   24'(rsp_tdata[65:45]));
            check_field("src_normal",      24'(w.nrm),   24'(rsp_tdata[86:66]));
            check_field("use_face_normal", 24'(w.face),  24'(rsp_tdata[87]));
            check_field("table_full",      24'(w.full),  24'(rsp_tdata[88]));
            check_field("count_saturated", 24'(w.sat),   24'(rsp_tdata[89]));
         end
      end
   end

   initial begin
      corner_t     seen[$];
      corner_t     c;
      logic [19:0] p;
      logic [19:0] q;
      int          random_items;
      int          mesh_len;
      int          r;

      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      req_gap = 0;
      rsp_gap = 0;
      fails = 0;
      cycle_count = 0;
      corners_sent = 0;
      corners_driven = 0;
      idle_level = 1;
      quiet_from = 0;
      slot_used = '0;
      vertex_count = '0;

      // directed: no mesh start after reset, extremes, absent encodings
      add_corner(1'b0, 20'h0_0000, 21'h00_0000, 21'h00_0000, 1'b0);
      add_corner(1'b0, 20'h0_0000, 21'h00_0000, 21'h00_0000, 1'b0);
      add_corner(1'b0, 20'hF_FFFF, 21'h0F_FFFF, 21'h0F_FFFF, 1'b0);
      add_corner(1'b0, 20'hF_FFFF, 21'h0F_FFFF, 21'h0F_FFFF, 1'b0);
      add_corner(1'b0, 20'd5, ABSENT, 21'd7, 1'b0);
      add_corner(1'b0, 20'd5, 21'h10_0000, 21'd7, 1'b0);
      add_corner(1'b0, 20'd5, 21'd3, ABSENT, 1'b0);
      add_corner(1'b0, 20'd5, 21'd3, ABSENT, 1'b0);
      add_corner(1'b0, 20'd5, 21'd3, 21'h1A_BCDE, 1'b0);
      add_corner(1'b0, 20'h0_0000, ABSENT, ABSENT, 1'b0);
      // collision chain on one home slot
      p = find_twin(20'd9, 21'd9, 21'd9);
      q = find_twin(p, 21'd9, 21'd9);
      add_corner(1'b0, 20'd9, 21'd9, 21'd9, 1'b0);
      add_corner(1'b0, p, 21'd9, 21'd9, 1'b0);
      add_corner(1'b0, 20'd9, 21'd9, 21'd9, 1'b0);
      add_corner(1'b0, p, 21'd9, 21'd9, 1'b0);
      add_corner(1'b0, q, 21'd9, 21'd9, 1'b1);
      add_corner(1'b0, p, 21'd9, 21'd9, 1'b0);
      // mesh start clears table and counter
      add_corner(1'b1, 20'h0_0000, 21'h00_0000, 21'h00_0000, 1'b0);
      add_corner(1'b1, 20'h0_0000, 21'h00_0000, 21'h00_0000, 1'b0);
      add_corner(1'b0, 20'h0_0000, 21'h00_0000, 21'h00_0000, 1'b0);
      add_corner(1'b1, 20'hF_FFFF, 21'h0F_FFFF, ABSENT, 1'b0);
      add_corner(1'b0, 20'd9, 21'd9, 21'd9, 1'b0);

      // random meshes: reuse, collisions and fresh corners
      random_items = 0;
      while (random_items < 1620) begin
         mesh_len = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 5) : $urandom_range(16, 48);
         seen.delete();
         for (int i = 0; i < mesh_len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40 && seen.size() != 0) begin
               c = seen[$urandom_range(0, seen.size() - 1)];
               c.tex = reencode(c.tex);
               c.nrm = reencode(c.nrm);
            end else if (r < 46 && seen.size() != 0) begin
               c = seen[$urandom_range(0, seen.size() - 1)];
               c.pos = find_twin(c.pos, c.tex, c.nrm);
               seen.insert(seen.size(), c);
            end else begin
               c.pos = pick_pos();
               c.tex = pick_attr();
               c.nrm = pick_attr();
               seen.insert(seen.size(), c);
            end
            add_corner(i == 0, c.pos, c.tex, c.nrm, $urandom_range(0, 149) == 0);
            random_items++;
         end
      end

      // closing corners, no idling over the last stretch
      quiet_from = corner_queue.size() - 150;
      add_corner(1'b0, 20'd77, 21'd1, ABSENT, 1'b0);
      add_corner(1'b0, 20'hF_FFFF, ABSENT, 21'd24, 1'b0);
      add_corner(1'b1, 20'hF_FFFF, ABSENT, 21'd24, 1'b0);
      add_corner(1'b0, 20'hF_FFFF, ABSENT, 21'd24, 1'b0);
      total_corners = corner_queue.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (corners_sent == total_corners && pending_vertices.size() == 0);
      repeat (40) @(posedge clock);
      if (fails == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
